>>> design/fqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue package
// Shared widths, action codes and controller/datapath signal groups for the
// ordered id queue with withdraw by id.
// ----------------------------------------------------------------------------
package fqc_pkg;

    localparam int DEPTH_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 16;

    localparam int ACTION_W = 2;
    localparam int EXT_ID_W = 16;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WITHDRAW = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE    = 2'd3;

    typedef struct packed {
        logic capture;
        logic search;
        logic apply;
    } fqc_cmd_t;

    typedef struct packed {
        logic needs_search;
    } fqc_stat_t;

endpackage

>>> design/fqc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue channels
// Valid/ready channels for action requests and for their results.
// ----------------------------------------------------------------------------
interface fqc_req_if import fqc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [EXT_ID_W-1:0] entry_id;

    modport source (output valid, output action, output entry_id, input ready);
    modport sink   (input valid, input action, input entry_id, output ready);
endinterface

interface fqc_rsp_if import fqc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                ok;
    logic [EXT_ID_W-1:0] removed_id;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output ok, output removed_id, output count, input ready);
    modport sink   (input valid, input ok, input removed_id, input count, output ready);
endinterface

>>> design/fifo_queue_with_cancel_by_id.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered id queue with withdraw by id
// Enqueue at the tail, dequeue from the head, or withdraw the first entry
// whose id matches; one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Enqueue and dequeue go from acceptance
// through the apply state to a valid result; withdraw passes through a search
// state first, in which the ids of all slots are compared before the slots
// behind the match shift up. The next request is accepted in the cycle after
// the result is taken. Slot contents are not cleared at reset; only the
// occupancy is.
module fifo_queue_with_cancel_by_id import fqc_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    fqc_req_if.sink      req,
    fqc_rsp_if.source    rsp
);

    fqc_cmd_t  cmd;
    fqc_stat_t stat;

    fqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fqc_dpath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (req.action),
        .entry_id   (req.entry_id),
        .ok         (rsp.ok),
        .removed_id (rsp.removed_id),
        .count      (rsp.count)
    );

endmodule

>>> design/fqc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue controller
// Sequences capture, optional id search, update and result hand-off.
// ----------------------------------------------------------------------------
module fqc_ctrl import fqc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  fqc_stat_t stat,
    output fqc_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = (state_reg == S_OUT);
    assign accept      = req_valid && req_ready;
    assign cmd.capture = accept;
    assign cmd.search  = (state_reg == S_SEARCH);
    assign cmd.apply   = (state_reg == S_APPLY);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.needs_search ? S_SEARCH : S_APPLY;
                end
            end
            S_SEARCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/fqc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue datapath
// Slot shift register with per-slot id compare, occupancy and result registers.
// ----------------------------------------------------------------------------
module fqc_dpath import fqc_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEFAULT,
    parameter int ID_BITS = ID_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fqc_cmd_t            cmd,
    output fqc_stat_t           stat,
    input  logic [ACTION_W-1:0] action,
    input  logic [EXT_ID_W-1:0] entry_id,
    output logic                ok,
    output logic [EXT_ID_W-1:0] removed_id,
    output logic [COUNT_W-1:0]  count
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int LOG_D = $clog2(DEPTH);

    logic [ACTION_W-1:0] act_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  slot_reg [DEPTH];
    logic [DEPTH-1:0]    match_reg;
    logic [DEPTH-1:0]    match_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic                ok_reg;
    logic                ok_next;
    logic [ID_BITS-1:0]  removed_reg;
    logic [ID_BITS-1:0]  removed_next;

    logic [DEPTH-1:0]    sel;
    logic [DEPTH-1:0]    shift_mask;
    logic [DEPTH-1:0]    first;
    logic                found;
    logic                enq_ok;

    assign stat.needs_search = (action == ACT_WITHDRAW);

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            match_next[k] = (slot_reg[k] == id_reg) && (OCC_W'(k) < occ_reg);
        end
    end

    always_comb
    begin
        sel = '0;
        priority if (act_reg == ACT_DEQUEUE)
        begin
            sel[0] = (occ_reg != '0);
        end
        else if (act_reg == ACT_WITHDRAW)
        begin
            sel = match_reg;
        end
        else
        begin
            sel = '0;
        end
    end

    always_comb
    begin
        shift_mask = sel;
        for (int s = 0; s < LOG_D; s++)
        begin
            shift_mask = shift_mask | (shift_mask << (1 << s));
        end
    end

    assign first  = shift_mask & ~(shift_mask << 1);
    assign found  = |sel;
    assign enq_ok = (act_reg == ACT_ENQUEUE) && (occ_reg < OCC_W'(DEPTH));

    always_comb
    begin
        removed_next = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (first[k])
            begin
                removed_next = removed_next | slot_reg[k];
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        ok_next  = 1'b0;
        if (enq_ok)
        begin
            occ_next = occ_reg + OCC_W'(1);
            ok_next  = 1'b1;
        end
        else if (found)
        begin
            occ_next = occ_reg - OCC_W'(1);
            ok_next  = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_slot
            always_ff @(posedge clk)
            begin
                if (cmd.apply)
                begin
                    if (enq_ok && (occ_reg == OCC_W'(g)))
                    begin
                        slot_reg[g] <= id_reg;
                    end
                    else if (shift_mask[g])
                    begin
                        if (g < DEPTH - 1)
                        begin
                            slot_reg[g] <= slot_reg[(g < DEPTH - 1) ? g + 1 : g];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            id_reg  <= ID_BITS'(entry_id);
        end
        if (cmd.search)
        begin
            match_reg <= match_next;
        end
        if (cmd.apply)
        begin
            ok_reg      <= ok_next;
            removed_reg <= removed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.apply)
        begin
            occ_reg <= occ_next;
        end
    end

    assign ok         = ok_reg;
    assign removed_id = EXT_ID_W'(removed_reg);
    assign count      = COUNT_W'(occ_reg);

endmodule
